>>> hw/rtl/crt3_pkg.sv
// shared types and constants of the three-moduli residue-to-binary converter
package crt3_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MOD_A = 2'd0;
    localparam logic [1:0] REG_MOD_B = 2'd1;
    localparam logic [1:0] REG_MOD_C = 2'd2;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_P12,
        S_P13,
        S_P23,
        S_NLO,
        S_NHI,
        S_CHK,
        S_NK_START,
        S_NK_DIV,
        S_EU_INIT,
        S_EU_TEST,
        S_EU_START,
        S_EU_DIV,
        S_EU_UPD,
        S_EU_END,
        S_CO_MUL,
        S_CO_START,
        S_CO_DIV,
        S_T_LO,
        S_T_HI,
        S_RED1,
        S_RED2,
        S_DONE
    } t_state;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_P12,
        OP_P13,
        OP_P23,
        OP_NLO,
        OP_NHI,
        OP_DIVS_NK,
        OP_DIVS_EU,
        OP_DIVS_CO,
        OP_DIV_STEP,
        OP_EU_INIT,
        OP_EU_UPD,
        OP_EU_END,
        OP_CO_MUL,
        OP_T_LO,
        OP_T_HI,
        OP_RED
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic r1_zero;
        logic bad;
    } t_dp_sts;

endpackage

>>> hw/rtl/crt3_ctrl.sv
// sequencer for the converter: products, three inverse runs, terms, reduction
module crt3_ctrl
    import crt3_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_done
);

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;

    // state and modulus index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        o_cmd.op = OP_NONE;
        o_cmd.k  = r_k;
        o_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_k      = 2'd0;
                    n_state  = S_P12;
                end
            end
            S_P12: begin
                o_cmd.op = OP_P12;
                n_state  = S_P13;
            end
            S_P13: begin
                o_cmd.op = OP_P13;
                n_state  = S_P23;
            end
            S_P23: begin
                o_cmd.op = OP_P23;
                n_state  = S_NLO;
            end
            S_NLO: begin
                o_cmd.op = OP_NLO;
                n_state  = S_NHI;
            end
            S_NHI: begin
                o_cmd.op = OP_NHI;
                n_state  = S_CHK;
            end
            S_CHK: begin
                // a zero modulus skips the whole computation
                if (i_sts.bad) n_state = S_DONE;
                else n_state = S_NK_START;
            end
            S_NK_START: begin
                o_cmd.op = OP_DIVS_NK;
                n_state  = S_NK_DIV;
            end
            S_NK_DIV: begin
                if (i_sts.div_done) n_state = S_EU_INIT;
                else o_cmd.op = OP_DIV_STEP;
            end
            S_EU_INIT: begin
                o_cmd.op = OP_EU_INIT;
                n_state  = S_EU_TEST;
            end
            S_EU_TEST: begin
                if (i_sts.r1_zero) n_state = S_EU_END;
                else n_state = S_EU_START;
            end
            S_EU_START: begin
                o_cmd.op = OP_DIVS_EU;
                n_state  = S_EU_DIV;
            end
            S_EU_DIV: begin
                if (i_sts.div_done) n_state = S_EU_UPD;
                else o_cmd.op = OP_DIV_STEP;
            end
            S_EU_UPD: begin
                o_cmd.op = OP_EU_UPD;
                n_state  = S_EU_TEST;
            end
            S_EU_END: begin
                o_cmd.op = OP_EU_END;
                n_state  = S_CO_MUL;
            end
            S_CO_MUL: begin
                o_cmd.op = OP_CO_MUL;
                n_state  = S_CO_START;
            end
            S_CO_START: begin
                o_cmd.op = OP_DIVS_CO;
                n_state  = S_CO_DIV;
            end
            S_CO_DIV: begin
                if (i_sts.div_done) n_state = S_T_LO;
                else o_cmd.op = OP_DIV_STEP;
            end
            S_T_LO: begin
                o_cmd.op = OP_T_LO;
                n_state  = S_T_HI;
            end
            S_T_HI: begin
                o_cmd.op = OP_T_HI;
                if (r_k == REG_MOD_C) begin
                    n_state = S_RED1;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_NK_START;
                end
            end
            S_RED1: begin
                o_cmd.op = OP_RED;
                n_state  = S_RED2;
            end
            S_RED2: begin
                o_cmd.op = OP_RED;
                n_state  = S_DONE;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hw/rtl/crt3_dp.sv
// datapath: shared multiplier, bit-serial divider, euclid registers, sum
module crt3_dp
    import crt3_pkg::*;
#(
    parameter int W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [W-1:0]     i_mod_a,
    input  logic [W-1:0]     i_mod_b,
    input  logic [W-1:0]     i_mod_c,
    input  logic [W-1:0]     i_res_a,
    input  logic [W-1:0]     i_res_b,
    input  logic [W-1:0]     i_res_c,
    output t_dp_sts          o_sts,
    output logic [3*W-1:0]   o_solution,
    output logic [3*W-1:0]   o_combined,
    output logic             o_bad
);

    localparam int D  = 2 * W;
    localparam int X  = 3 * W;
    localparam int SW = 3 * W + 2;
    localparam int TW = W + 2;
    localparam int CW = $clog2(D + 1);
    localparam logic [CW-1:0] DSTEPS = CW'(D);

    logic [W-1:0]         r_res [3];
    logic [D-1:0]         r_p12, r_p13, r_p23;
    logic [X-1:0]         r_bign;
    logic [SW-1:0]        r_sum;
    logic                 r_bad;
    logic [W-1:0]         r_rem, r_div;
    logic [D-1:0]         r_dq, r_prod;
    logic [CW-1:0]        r_dcnt;
    logic [W-1:0]         r_r0, r_r1, r_inv;
    logic signed [TW-1:0] r_t0, r_t1;

    logic [W-1:0]          nk_mod, bk;
    logic [D-1:0]          nk_big;
    logic [W-1:0]          mul_x, mul_y;
    logic [D-1:0]          mul_p;
    logic [W:0]            dv_trial;
    logic                  dv_ge;
    logic signed [2*W+2:0] qt;
    logic signed [TW:0]    tn, tn2, nk_s;

    // operand selection by modulus index
    always_comb begin
        unique case (i_cmd.k)
            REG_MOD_A: begin nk_mod = i_mod_a; nk_big = r_p23; bk = r_res[0]; end
            REG_MOD_B: begin nk_mod = i_mod_b; nk_big = r_p13; bk = r_res[1]; end
            REG_MOD_C: begin nk_mod = i_mod_c; nk_big = r_p12; bk = r_res[2]; end
            default:   begin nk_mod = i_mod_a; nk_big = r_p23; bk = r_res[0]; end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mul_x = i_mod_a;
        mul_y = i_mod_b;
        unique case (i_cmd.op)
            OP_P13:    begin mul_x = i_mod_a;          mul_y = i_mod_c;          end
            OP_P23:    begin mul_x = i_mod_b;          mul_y = i_mod_c;          end
            OP_NLO:    begin mul_x = r_p12[W-1:0];     mul_y = i_mod_c;          end
            OP_NHI:    begin mul_x = r_p12[D-1:W];     mul_y = i_mod_c;          end
            OP_CO_MUL: begin mul_x = bk;               mul_y = r_inv;            end
            OP_T_LO:   begin mul_x = r_rem;            mul_y = nk_big[W-1:0];    end
            OP_T_HI:   begin mul_x = r_rem;            mul_y = nk_big[D-1:W];    end
            default:   begin mul_x = i_mod_a;          mul_y = i_mod_b;          end
        endcase
        mul_p = D'(mul_x) * D'(mul_y);
    end

    // one restoring division bit
    assign dv_trial = {r_rem, r_dq[D-1]};
    assign dv_ge    = (dv_trial >= {1'b0, r_div});

    // euclid coefficient update and final inverse fix-up
    assign qt   = (2*W+3)'($signed({1'b0, r_dq[W-1:0]})) * (2*W+3)'(r_t1);
    assign nk_s = $signed({3'b000, nk_mod});
    assign tn   = (r_t0 < 0) ? ((TW+1)'(r_t0) + nk_s) : (TW+1)'(r_t0);
    assign tn2  = (tn >= nk_s) ? (tn - nk_s) : tn;

    // control flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad  <= 1'b0;
            r_dcnt <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD:    r_bad <= (i_mod_a == '0) || (i_mod_b == '0) || (i_mod_c == '0);
                OP_EU_END:  r_bad <= r_bad || (r_r0 != W'(1));
                default:    r_bad <= r_bad;
            endcase
            unique case (i_cmd.op)
                OP_DIVS_NK, OP_DIVS_EU, OP_DIVS_CO: r_dcnt <= DSTEPS;
                OP_DIV_STEP:                        r_dcnt <= r_dcnt - CW'(1);
                default:                            r_dcnt <= r_dcnt;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_res[0] <= i_res_a;
                r_res[1] <= i_res_b;
                r_res[2] <= i_res_c;
                r_sum    <= '0;
            end
            OP_P12: r_p12  <= mul_p;
            OP_P13: r_p13  <= mul_p;
            OP_P23: r_p23  <= mul_p;
            OP_NLO: r_bign <= X'(mul_p);
            OP_NHI: r_bign <= r_bign + (X'(mul_p) << W);
            OP_DIVS_NK: begin
                r_dq  <= nk_big;
                r_div <= nk_mod;
                r_rem <= '0;
            end
            OP_DIVS_EU: begin
                r_dq  <= D'(r_r0);
                r_div <= r_r1;
                r_rem <= '0;
            end
            OP_DIVS_CO: begin
                r_dq  <= r_prod;
                r_div <= nk_mod;
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= dv_ge ? W'(dv_trial - {1'b0, r_div}) : dv_trial[W-1:0];
                r_dq  <= {r_dq[D-2:0], dv_ge};
            end
            OP_EU_INIT: begin
                r_r0 <= nk_mod;
                r_r1 <= r_rem;
                r_t0 <= '0;
                r_t1 <= TW'(1);
            end
            OP_EU_UPD: begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_t0 <= r_t1;
                r_t1 <= TW'((2*W+3)'(r_t0) - qt);
            end
            OP_EU_END: r_inv  <= tn2[W-1:0];
            OP_CO_MUL: r_prod <= mul_p;
            OP_T_LO:   r_sum  <= r_sum + SW'(mul_p);
            OP_T_HI:   r_sum  <= r_sum + (SW'(mul_p) << W);
            OP_RED: begin
                if (r_sum >= SW'(r_bign)) r_sum <= r_sum - SW'(r_bign);
            end
            default: ;
        endcase
    end

    assign o_sts.div_done = (r_dcnt == '0);
    assign o_sts.r1_zero  = (r_r1 == '0);
    assign o_sts.bad      = r_bad;

    assign o_solution = r_bad ? '0 : r_sum[X-1:0];
    assign o_combined = r_bign;
    assign o_bad      = r_bad;

endmodule

>>> hw/rtl/crt_three_moduli_reconstruct.sv
// top level of the three-moduli residue-to-binary converter
//
//  channel   handshake            payload
//  input     start / busy         i_residue_a, i_residue_b, i_residue_c
//  result    o_done (strobe)      o_solution, o_combined_modulus, o_not_coprime
//  config    apb psel/penable     paddr, pwdata, prdata (moduli a, b, c)
//
// every division in an item uses the shared one-bit-per-cycle divider running 2*W
// steps, W = MODULUS_BITS; zero moduli skip from the check to done, with no division.
// reset sets all three moduli to 1 and returns the sequencer to idle.
// busy stays high from acceptance through the cycle of o_done; the receiver
// cannot stall, each result is shown for one cycle only.
module crt_three_moduli_reconstruct
    import crt3_pkg::*;
#(
    parameter int MODULUS_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODULUS_BITS-1:0]   i_residue_a,
    input  logic [MODULUS_BITS-1:0]   i_residue_b,
    input  logic [MODULUS_BITS-1:0]   i_residue_c,
    output logic                      o_done,
    output logic [3*MODULUS_BITS-1:0] o_solution,
    output logic [3*MODULUS_BITS-1:0] o_combined_modulus,
    output logic                      o_not_coprime,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int W = MODULUS_BITS;

    logic [W-1:0] r_mod_a, r_mod_b, r_mod_c;
    logic [1:0]   reg_idx;
    logic         wr_en;
    t_dp_cmd      cmd;
    t_dp_sts      sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // modulus registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_a <= W'(1);
            r_mod_b <= W'(1);
            r_mod_c <= W'(1);
        end else if (wr_en) begin
            if (reg_idx == REG_MOD_A) r_mod_a <= pwdata[W-1:0];
            if (reg_idx == REG_MOD_B) r_mod_b <= pwdata[W-1:0];
            if (reg_idx == REG_MOD_C) r_mod_c <= pwdata[W-1:0];
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_MOD_A: prdata = 32'(r_mod_a);
            REG_MOD_B: prdata = 32'(r_mod_b);
            REG_MOD_C: prdata = 32'(r_mod_c);
            default:   prdata = '0;
        endcase
    end

    crt3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    crt3_dp #(
        .W (W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_mod_a    (r_mod_a),
        .i_mod_b    (r_mod_b),
        .i_mod_c    (r_mod_c),
        .i_res_a    (i_residue_a),
        .i_res_b    (i_residue_b),
        .i_res_c    (i_residue_c),
        .o_sts      (sts),
        .o_solution (o_solution),
        .o_combined (o_combined_modulus),
        .o_bad      (o_not_coprime)
    );

    // a result only appears while an item is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result strobe outside an item");

    // an accepted item occupies the block
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not start");

    // a valid solution lies below the combined modulus
    a_sol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_not_coprime) |-> (o_solution < o_combined_modulus))
        else $error("solution not reduced");

endmodule

>>> tb/tb_top.sv
// testbench of the three-moduli residue-to-binary converter
`timescale 1ns / 1ps

module tb_top
    import crt3_pkg::*;
();

    localparam int MW = 12;
    localparam int OW = 3 * MW;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [MW-1:0] i_residue_a;
    logic [MW-1:0] i_residue_b;
    logic [MW-1:0] i_residue_c;
    logic          o_done;
    logic [OW-1:0] o_solution;
    logic [OW-1:0] o_combined_modulus;
    logic          o_not_coprime;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    typedef struct packed {
        logic [OW-1:0] solution;
        logic [OW-1:0] product;
        logic          shared;
    } t_crt_result;

    // moduli as the block should hold them
    logic [MW-1:0] mod_a, mod_b, mod_c;
    t_crt_result   pending_results[$];
    int            errors;
    int            send_idle_pct;

    crt_three_moduli_reconstruct #(.MODULUS_BITS(MW)) dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #100ms;
        $display("crt_three_moduli_reconstruct test failed");
        $finish;
    end

    function automatic longint gcd_u(longint p, longint q);
        longint r;
        while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    // inverse of v modulo n by extended euclid
    function automatic longint inv_mod(longint v, longint n);
        longint r0, r1, t0, t1, q, tmp;
        if (n <= 1) return 0;
        r0 = n;
        r1 = v % n;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - q * t1;
            t0 = t1;
            t1 = tmp;
        end
        if (t0 < 0) t0 += n;
        return t0 % n;
    endfunction

    function automatic longint crt_part(longint b, longint n, longint nk);
        longint coef;
        coef = ((b % n) * inv_mod(nk % n, n)) % n;
        return coef * nk;
    endfunction

    // reconstruct x from three residues under the current moduli
    function automatic t_crt_result reconstruct(logic [MW-1:0] ra, logic [MW-1:0] rb,
                                                logic [MW-1:0] rc);
        t_crt_result res;
        longint n1, n2, n3, nn, acc;
        logic bad;
        n1 = longint'(mod_a);
        n2 = longint'(mod_b);
        n3 = longint'(mod_c);
        nn = n1 * n2 * n3;
        if (n1 == 0 || n2 == 0 || n3 == 0) bad = 1'b1;
        else bad = gcd_u(n1, n2) != 1 || gcd_u(n1, n3) != 1 || gcd_u(n2, n3) != 1;
        res.solution = '0;
        if (!bad) begin
            acc = crt_part(longint'(ra), n1, n2 * n3) + crt_part(longint'(rb), n2, n1 * n3)
                + crt_part(longint'(rc), n3, n1 * n2);
            res.solution = OW'(acc % nn);
        end
        res.product = OW'(nn);
        res.shared = bad;
        return res;
    endfunction

    // compare every strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_crt_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result sol=%0d n=%0d nc=%0b", $time,
                         o_solution, o_combined_modulus, o_not_coprime);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_solution !== want.solution) begin
                    $display("%0t: solution expected %0d actual %0d", $time,
                             want.solution, o_solution);
                    errors++;
                end
                if (o_combined_modulus !== want.product) begin
                    $display("%0t: combined_modulus expected %0d actual %0d", $time,
                             want.product, o_combined_modulus);
                    errors++;
                end
                if (o_not_coprime !== want.shared) begin
                    $display("%0t: not_coprime expected %0b actual %0b", $time,
                             want.shared, o_not_coprime);
                    errors++;
                end
            end
        end
    end

    // send one item, with a random gap before it
    task automatic send_item(logic [MW-1:0] ra, logic [MW-1:0] rb, logic [MW-1:0] rc);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        start <= 1'b1;
        i_residue_a <= ra;
        i_residue_b <= rb;
        i_residue_c <= rc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.insert(pending_results.size(), reconstruct(ra, rb, rc));
        start <= 1'b0;
        i_residue_a <= MW'($urandom);
        i_residue_b <= MW'($urandom);
        i_residue_c <= MW'($urandom);
        // the block is busy after acceptance
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write, idle only; indexes past the last register are ignored
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MOD_A: mod_a = val[MW-1:0];
            REG_MOD_B: mod_b = val[MW-1:0];
            REG_MOD_C: mod_c = val[MW-1:0];
            default: ;
        endcase
        // return to idle between transfers
        @(posedge i_clk);
    endtask

    task automatic set_moduli(logic [MW-1:0] a, logic [MW-1:0] b, logic [MW-1:0] c);
        wait_drained();
        write_reg(REG_MOD_A, {$urandom} << MW | a);
        write_reg(REG_MOD_B, 32'(b));
        write_reg(REG_MOD_C, 32'(c));
    endtask

    function automatic logic [MW-1:0] rand_res();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return MW'($urandom);
        endcase
    endfunction

    // extremes of residues and moduli, and each special case
    task automatic test_directed();
        send_item('0, '0, '0);
        send_item('1, '1, '1);
        set_moduli(12'd4095, 12'd4094, 12'd4093);
        send_item('0, '0, '0);
        send_item('1, '1, '1);
        send_item(12'd4094, 12'd4093, 12'd4092);
        send_item(12'h555, 12'haaa, 12'h001);
        set_moduli(12'd3, 12'd5, 12'd7);
        send_item(12'd2, 12'd3, 12'd2);
        send_item(12'd4095, 12'd4095, 12'd4095);
        set_moduli(12'd6, 12'd10, 12'd7);
        send_item(12'd1, 12'd3, 12'd5);
        set_moduli(12'd0, 12'd5, 12'd7);
        send_item(12'd1, 12'd2, 12'd3);
        set_moduli(12'd1, 12'd1, 12'd4093);
        send_item(12'd9, 12'd9, 12'd4000);
        set_moduli(12'd4093, 12'd1, 12'd0);
        send_item(12'd5, 12'd5, 12'd5);
        set_moduli(12'd2, 12'd4095, 12'd4093);
        send_item(12'd1, 12'd4094, 12'd17);
    endtask

    // random moduli sets, mostly coprime, residues random
    task automatic test_random(int n_items);
        logic [MW-1:0] a, b, c;
        for (int i = 0; i < n_items; i++) begin
            if (i % 20 == 0) begin
                a = MW'($urandom_range(4095, 1));
                if ($urandom_range(3) == 0) b = MW'($urandom);
                else begin
                    b = MW'($urandom_range(4095, 1));
                    while (gcd_u(longint'(a), longint'(b)) != 1)
                        b = MW'($urandom_range(4095, 1));
                end
                if ($urandom_range(3) == 0) c = MW'($urandom);
                else begin
                    c = MW'($urandom_range(4095, 1));
                    while (gcd_u(longint'(a), longint'(c)) != 1 ||
                           gcd_u(longint'(b), longint'(c)) != 1)
                        c = MW'($urandom_range(4095, 1));
                end
                set_moduli(a, b, c);
            end
            send_item(rand_res(), rand_res(), rand_res());
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 25;
        mod_a = MW'(1);
        mod_b = MW'(1);
        mod_c = MW'(1);
        i_rst_n = 1'b0;
        start = 1'b0;
        i_residue_a = '0;
        i_residue_b = '0;
        i_residue_c = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600);
        send_idle_pct = 80;
        test_random(600);
        send_idle_pct = 0;
        test_random(600);
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("crt_three_moduli_reconstruct test passed");
        end else begin
            $display("crt_three_moduli_reconstruct test failed");
        end
        $finish;
    end

endmodule
